// ===== rtl/core/tmi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tmi_pkg;

  localparam int VALUE_W = 4;
  localparam int SIZE_W = 5;
  localparam int INDEX_W = 4;
  localparam int COST_W = 7;
  localparam int SIZE_LIMIT = 2 ** SIZE_W - 1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;
  localparam logic [COST_W-1:0] COST_MAX = 7'd127;

  typedef struct packed {
    logic [VALUE_W-1:0] perm_value;
  } item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] rotation_index;
    logic [COST_W-1:0]  rotation_cost;
    logic [COST_W-1:0]  running_minimum;
    logic               last_of_run;
  } result_t;

  typedef logic [SIZE_W-1:0] size_t;

endpackage

`default_nettype wire

// ===== rtl/core/tmi_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tmi_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tmi_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tmi_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/toric_min_inversion.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Toric minimum-inversion engine.
// The items channel takes one permutation element per request, in position
// order. The cfg channel writes the set size n; a write drops any partly
// loaded set and is taken only while the block is idle.
// Loading element p walks the p stored elements through the element memory
// to count inversions, with a read state and a compare state per element,
// then a write state. The n-th element starts n rotations. Each rotation
// walks the position memory, a read state and an update state per value,
// with repeated reduce steps where a stale position needs reducing, then an
// output state emits its result and, but for the last rotation, read and
// update states fetch the element that updates the inversion count.
// Results leave through an output register on the results channel. When the
// receiver stalls, the next rotation waits, but once the last result is in
// the register the block goes idle and accepts new elements.
// Reset returns the size to 16, clears the load count and the result valid
// flag; the memories keep their contents and need no clearing.

module toric_min_inversion #(
  parameter int MAX_ELEMENTS = 16
) (
  input wire logic   clk,
  input wire logic   rst,
  tmi_stream_if.sink   items,
  tmi_stream_if.source results,
  tmi_stream_if.sink   cfg
);

  import tmi_pkg::*;

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int NMAX = (MAX_ELEMENTS < SIZE_LIMIT) ? MAX_ELEMENTS : SIZE_LIMIT;
  localparam int NW = $clog2(NMAX + 1);
  localparam int INV_W = $clog2(NMAX * (NMAX - 1) / 2 + 1);
  localparam int SW = $clog2(4 * NMAX * NMAX + 64 * NMAX + 1) + 2;
  localparam int XW = (AW > NW) ? AW : NW;
  localparam int PW = 2 * AW;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_RD,
    S_LD_CMP,
    S_LD_WR,
    S_RT_RD,
    S_RT_UPD,
    S_RT_MOD,
    S_RT_OUT,
    S_RT_SV,
    S_RT_INV
  } state_t;

  state_t state;

  size_t                 size_reg;
  logic [NW-1:0]         loaded;
  logic [INV_W-1:0]      inv_tot;
  logic [VALUE_W-1:0]    vin;
  logic [NW-1:0]         ploc;
  logic [NW-1:0]         j;
  logic [NW-1:0]         q;
  logic [NW-1:0]         k;
  logic signed [SW-1:0]  acc;
  logic signed [SW-1:0]  mn;
  logic signed [SW-1:0]  inv_run;
  logic [AW-1:0]         xred;
  logic [AW-1:0]         hold_vp;
  logic [COST_W-1:0]     best;
  logic                  out_valid;
  result_t               out_data;

  logic [NW-1:0]         n_act;
  logic [NW-1:0]         p_eff;
  logic signed [SW-1:0]  nm1_s;
  logic [AW-1:0]         x_sel;
  logic                  x_lt_n;
  logic [AW-1:0]         x_dec;
  logic signed [SW-1:0]  acc_next;
  logic signed [SW-1:0]  mn_next;
  logic                  red_lt_n;
  logic signed [SW-1:0]  cost_s;
  logic [COST_W-1:0]     cost_c;
  logic [COST_W-1:0]     best_next;
  logic signed [SW-1:0]  inv_next;
  logic                  out_free;

  logic                  sv_we;
  logic [AW-1:0]         sv_waddr;
  logic [AW-1:0]         sv_raddr;
  logic [VALUE_W-1:0]    sv_rd;
  logic                  pos_we;
  logic [AW-1:0]         pos_waddr;
  logic [PW-1:0]         pos_wdata;
  logic [AW-1:0]         pos_raddr;
  logic [PW-1:0]         pos_rd;

  tmi_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ELEMENTS)) u_values (
    .clk   (clk),
    .we    (sv_we),
    .waddr (sv_waddr),
    .wdata (vin),
    .raddr (sv_raddr),
    .rdata (sv_rd)
  );

  tmi_ram #(.WIDTH(PW), .DEPTH(MAX_ELEMENTS)) u_positions (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rd)
  );

  assign items.ready = (state == S_IDLE) && !cfg.valid;
  assign cfg.ready = (state == S_IDLE);
  assign results.valid = out_valid;
  assign results.data = out_data;

  always_comb begin
    if (size_reg == '0) begin
      n_act = NW'(1);
    end else if (32'(size_reg) > MAX_ELEMENTS) begin
      n_act = NW'(MAX_ELEMENTS);
    end else begin
      n_act = NW'(size_reg);
    end
  end

  assign p_eff = (loaded >= n_act) ? '0 : loaded;
  assign nm1_s = $signed({{(SW - NW){1'b0}}, n_act}) - $signed(SW'(1));

  assign x_sel = (q == '0) ? pos_rd[PW-1:AW] : pos_rd[AW-1:0];
  assign x_lt_n = XW'(x_sel) < XW'(n_act);
  assign x_dec = (x_sel == '0) ? AW'(n_act - NW'(1)) : x_sel - AW'(1);
  assign acc_next = acc + nm1_s - $signed({{(SW - AW - 1){1'b0}}, x_sel, 1'b0});
  assign mn_next = (acc_next < mn) ? acc_next : mn;
  assign red_lt_n = XW'(xred) < XW'(n_act);

  assign cost_s = inv_run + mn;
  always_comb begin
    if (cost_s < $signed(SW'(0))) begin
      cost_c = '0;
    end else if (cost_s > $signed(SW'(COST_MAX))) begin
      cost_c = COST_MAX;
    end else begin
      cost_c = COST_W'(cost_s);
    end
  end
  assign best_next = (cost_c < best) ? cost_c : best;
  assign inv_next = inv_run + nm1_s - $signed({{(SW - VALUE_W - 1){1'b0}}, sv_rd, 1'b0});
  assign out_free = !out_valid || results.ready;

  always_comb begin
    sv_we = (state == S_LD_WR);
    sv_waddr = AW'(ploc);
    sv_raddr = (state == S_RT_SV) ? AW'(q) : AW'(j);
    pos_raddr = AW'(k);
    pos_we = 1'b0;
    pos_waddr = AW'(k);
    pos_wdata = {pos_rd[PW-1:AW], x_dec};
    case (state)
      S_LD_WR: begin
        pos_we = 32'(vin) < MAX_ELEMENTS;
        pos_waddr = AW'(vin);
        pos_wdata = {AW'(ploc), AW'(0)};
      end
      S_RT_UPD: begin
        pos_we = x_lt_n;
      end
      S_RT_MOD: begin
        pos_we = red_lt_n;
        pos_wdata = {hold_vp, xred};
      end
      default: begin
        pos_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      size_reg <= SIZE_RESET;
      loaded <= '0;
      inv_tot <= '0;
      best <= COST_MAX;
      out_valid <= 1'b0;
    end else begin
      if (results.ready && state != S_RT_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cfg.valid) begin
            size_reg <= cfg.data;
            loaded <= '0;
            inv_tot <= '0;
          end else if (items.valid) begin
            vin <= items.data.perm_value;
            ploc <= p_eff;
            j <= '0;
            if (loaded >= n_act) begin
              inv_tot <= '0;
            end
            state <= (p_eff == '0) ? S_LD_WR : S_LD_RD;
          end
        end
        S_LD_RD: begin
          state <= S_LD_CMP;
        end
        S_LD_CMP: begin
          if (sv_rd > vin) begin
            inv_tot <= inv_tot + INV_W'(1);
          end
          j <= j + NW'(1);
          state <= (j + NW'(1) == ploc) ? S_LD_WR : S_LD_RD;
        end
        S_LD_WR: begin
          loaded <= ploc + NW'(1);
          if (ploc + NW'(1) == n_act) begin
            q <= '0;
            k <= '0;
            acc <= '0;
            mn <= '0;
            inv_run <= SW'(inv_tot);
            best <= COST_MAX;
            state <= S_RT_RD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_RT_RD: begin
          state <= S_RT_UPD;
        end
        S_RT_UPD: begin
          acc <= acc_next;
          mn <= mn_next;
          hold_vp <= pos_rd[PW-1:AW];
          if (x_lt_n) begin
            k <= k + NW'(1);
            state <= (k + NW'(1) == n_act) ? S_RT_OUT : S_RT_RD;
          end else begin
            xred <= x_sel - AW'(1);
            state <= S_RT_MOD;
          end
        end
        S_RT_MOD: begin
          if (red_lt_n) begin
            k <= k + NW'(1);
            state <= (k + NW'(1) == n_act) ? S_RT_OUT : S_RT_RD;
          end else begin
            xred <= xred - AW'(n_act);
          end
        end
        S_RT_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data.rotation_index <= INDEX_W'(q);
            out_data.rotation_cost <= cost_c;
            out_data.running_minimum <= best_next;
            out_data.last_of_run <= (q + NW'(1) == n_act);
            best <= best_next;
            if (q + NW'(1) == n_act) begin
              loaded <= '0;
              inv_tot <= '0;
              state <= S_IDLE;
            end else begin
              state <= S_RT_SV;
            end
          end
        end
        S_RT_SV: begin
          state <= S_RT_INV;
        end
        S_RT_INV: begin
          inv_run <= inv_next;
          q <= q + NW'(1);
          k <= '0;
          acc <= '0;
          mn <= '0;
          state <= S_RT_RD;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tmi_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tmi_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             item_valid,
  input wire logic             item_ready,
  input wire logic             res_valid,
  input wire logic             res_ready,
  input wire tmi_pkg::result_t res_data
);

  import tmi_pkg::*;

  // The running minimum never exceeds the cost of the same rotation.
  a_min_le_cost: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data.running_minimum <= res_data.rotation_cost)
    else $error("running minimum above rotation cost");

  // The first rotation of a set starts the running minimum.
  a_first_min: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.rotation_index == '0) |->
      res_data.running_minimum == res_data.rotation_cost)
    else $error("first rotation does not start the running minimum");

  // An accepted element keeps the block busy in the following cycle.
  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("element request accepted in back-to-back cycles");

  // A stalled result holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
    else $error("stalled result changed");

endmodule

bind toric_min_inversion tmi_checker u_tmi_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (items.valid),
  .item_ready (items.ready),
  .res_valid  (results.valid),
  .res_ready  (results.ready),
  .res_data   (results.data)
);

`default_nettype wire

// ===== sim/tb_toric_min_inversion.sv =====
`timescale 1ns / 1ps

module tb_toric_min_inversion;
  import tmi_pkg::*;

  localparam int MAX_ELEMENTS = 16;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES = 3000;
  localparam int END_CYCLES = 100;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DIRECTED_VALUES = 24;
  localparam int RANDOM_VALUES = 176;

  typedef enum {
    STEP_VALUE,
    STEP_SIZE,
    STEP_DRAIN,
    STEP_HOLD,
    STEP_CALM
  } step_kind_t;

  typedef struct {
    step_kind_t       kind;
    logic [SIZE_W-1:0] arg;
  } plan_step_t;

  logic clk;
  logic rst;

  tmi_stream_if #(.payload_t(item_t))   items_bus ();
  tmi_stream_if #(.payload_t(result_t)) result_bus ();
  tmi_stream_if #(.payload_t(size_t))   cfg_bus ();

  toric_min_inversion #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .items   (items_bus),
    .results (result_bus),
    .cfg     (cfg_bus)
  );

  plan_step_t request_plan[$];
  result_t    due_rotations[$];
  int         planned_values;
  int         bad_results;

  int          elem_at[MAX_ELEMENTS];
  int          pos_of[MAX_ELEMENTS];
  int          elems_loaded;
  int          pair_inversions;
  logic [SIZE_W-1:0] set_size;

  bit item_live;
  bit cfg_live;
  bit item_taken;
  bit size_taken;
  bit hold_request;
  bit calm;
  bit send_lively;
  bit take_lively;
  bit ready_now;
  int gap_left;
  int settle;
  int send_spell;
  int take_spell;
  int stall_left;
  int hold_left;

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  function automatic int active_count(input logic [SIZE_W-1:0] size);
    if (size == '0) begin
      return 1;
    end
    if (size > MAX_ELEMENTS) begin
      return MAX_ELEMENTS;
    end
    return int'(size);
  endfunction

  // Loads one element and, once the set is complete, queues the cost of every rotation.
  task automatic load_element(input logic [VALUE_W-1:0] value);
    int n;
    int p;
    int acc;
    int low;
    int cost;
    int best;
    int turned_inv;
    int spot[MAX_ELEMENTS];
    result_t rot;
    n = active_count(set_size);
    p = elems_loaded;
    if (p >= n) begin
      p = 0;
      pair_inversions = 0;
    end
    for (int j = 0; j < p; j++) begin
      if (elem_at[j] > int'(value)) begin
        pair_inversions++;
      end
    end
    elem_at[p] = int'(value);
    pos_of[value] = p;
    elems_loaded = p + 1;
    if (elems_loaded < n) begin
      return;
    end
    for (int k = 0; k < n; k++) begin
      spot[k] = pos_of[k];
    end
    turned_inv = pair_inversions;
    best = 127;
    for (int q = 0; q < n; q++) begin
      acc = 0;
      low = 0;
      for (int k = 0; k < n; k++) begin
        acc += n - 1 - 2 * spot[k];
        if (acc < low) begin
          low = acc;
        end
      end
      cost = turned_inv + low;
      if (cost < 0) begin
        cost = 0;
      end
      if (cost > 127) begin
        cost = 127;
      end
      if (cost < best) begin
        best = cost;
      end
      rot.rotation_index = q[INDEX_W-1:0];
      rot.rotation_cost = cost[COST_W-1:0];
      rot.running_minimum = best[COST_W-1:0];
      rot.last_of_run = (q + 1 == n);
      due_rotations.push_back(rot);
      if (q + 1 < n) begin
        turned_inv += n - 1 - 2 * elem_at[q];
        for (int k = 0; k < n; k++) begin
          spot[k] = (spot[k] + n - 1) % n;
        end
      end
    end
    elems_loaded = 0;
    pair_inversions = 0;
  endtask

  task automatic add_step(input step_kind_t kind, input int arg);
    plan_step_t s;
    s.kind = kind;
    s.arg = arg[SIZE_W-1:0];
    request_plan.push_back(s);
    if (kind == STEP_VALUE) begin
      planned_values++;
    end
  endtask

  task automatic add_shuffled(input int n, input int len);
    int order[MAX_ELEMENTS];
    int pick;
    int swap;
    for (int i = 0; i < n; i++) begin
      order[i] = i;
    end
    for (int i = n - 1; i > 0; i--) begin
      pick = $urandom_range(0, i);
      swap = order[i];
      order[i] = order[pick];
      order[pick] = swap;
    end
    for (int i = 0; i < len; i++) begin
      add_step(STEP_VALUE, order[i]);
    end
  endtask

  initial begin
    rst = 1'b1;
    items_bus.valid = 1'b0;
    items_bus.data = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    result_bus.ready = 1'b0;
    set_size = SIZE_RESET;
    elems_loaded = 0;
    pair_inversions = 0;
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      elem_at[i] = 0;
      pos_of[i] = 0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  initial begin : plan_and_finish
    int size;
    int n;
    int sets;
    int phase;
    int kind;
    bit calm_queued;
    int forced_sizes[4];
    forced_sizes = '{31, 17, 1, 16};
    calm_queued = 1'b0;

    // A full reversed set at the reset size writes every position entry once.
    for (int v = MAX_ELEMENTS - 1; v >= 0; v--) begin
      add_step(STEP_VALUE, v);
    end
    add_step(STEP_SIZE, 0);
    add_step(STEP_VALUE, 0);
    add_step(STEP_VALUE, 15);
    add_step(STEP_SIZE, 3);
    add_step(STEP_VALUE, 2);
    add_step(STEP_VALUE, 1);
    add_step(STEP_SIZE, 2);
    add_step(STEP_VALUE, 1);
    add_step(STEP_VALUE, 0);
    add_step(STEP_VALUE, 1);
    add_step(STEP_VALUE, 1);

    phase = 0;
    while (planned_values < DIRECTED_VALUES + RANDOM_VALUES) begin
      if (phase < 4) begin
        size = forced_sizes[phase];
      end else if ($urandom_range(0, 2) == 0) begin
        size = $urandom_range(0, 31);
      end else begin
        size = $urandom_range(1, 8);
      end
      add_step(STEP_SIZE, size);
      n = active_count(size[SIZE_W-1:0]);
      if (phase == 0) begin
        add_step(STEP_HOLD, 0);
      end
      if (phase == 2) begin
        add_step(STEP_DRAIN, 0);
      end
      sets = $urandom_range(2, 4);
      for (int s = 0; s < sets; s++) begin
        kind = $urandom_range(0, 9);
        if (kind == 0 && n > 1) begin
          add_shuffled(n, $urandom_range(1, n - 1));
          break;
        end else if (kind == 1) begin
          for (int i = 0; i < n; i++) begin
            add_step(STEP_VALUE, $urandom_range(0, 15));
          end
        end else begin
          add_shuffled(n, n);
        end
        if ($urandom_range(0, 7) == 0) begin
          add_step(STEP_DRAIN, 0);
        end
      end
      if (!calm_queued && planned_values > DIRECTED_VALUES + RANDOM_VALUES - 40) begin
        add_step(STEP_CALM, 0);
        calm_queued = 1'b1;
      end
      phase++;
    end

    while (request_plan.size() != 0 || item_live || cfg_live ||
           due_rotations.size() != 0) begin
      @(posedge clk);
    end
    repeat (END_CYCLES) @(posedge clk);
    if (bad_results == 0 && due_rotations.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // The sender drops a taken request on the falling edge; a random gap may then follow.
  always @(negedge clk) begin
    if (!rst) begin
      if (item_taken) begin
        item_live = 1'b0;
        item_taken = 1'b0;
        if (!calm && send_lively && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(1, 15);
        end
      end
      if (size_taken) begin
        cfg_live = 1'b0;
        size_taken = 1'b0;
      end
      if (due_rotations.size() != 0 || item_live) begin
        settle = 0;
      end else if (settle < SETTLE_CYCLES) begin
        settle++;
      end
      if (send_spell == 0) begin
        send_spell = $urandom_range(50, 300);
        send_lively = ($urandom_range(0, 2) != 0);
      end else begin
        send_spell--;
      end
      if (!item_live && !cfg_live && request_plan.size() != 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          case (request_plan[0].kind)
            STEP_VALUE: begin
              item_live = 1'b1;
              items_bus.data.perm_value <= request_plan[0].arg[VALUE_W-1:0];
              void'(request_plan.pop_front());
            end
            STEP_SIZE: begin
              if (settle >= SETTLE_CYCLES) begin
                cfg_live = 1'b1;
                cfg_bus.data <= request_plan[0].arg;
                void'(request_plan.pop_front());
              end
            end
            STEP_DRAIN: begin
              if (due_rotations.size() == 0) begin
                void'(request_plan.pop_front());
              end
            end
            STEP_HOLD: begin
              hold_request = 1'b1;
              void'(request_plan.pop_front());
            end
            STEP_CALM: begin
              calm = 1'b1;
              void'(request_plan.pop_front());
            end
            default: begin
              void'(request_plan.pop_front());
            end
          endcase
        end
      end
      items_bus.valid <= item_live;
      cfg_bus.valid <= cfg_live;
    end
  end

  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (take_spell == 0) begin
      take_spell = $urandom_range(50, 300);
      take_lively = ($urandom_range(0, 2) != 0);
    end else begin
      take_spell--;
    end
    if (hold_left > 0) begin
      hold_left--;
      ready_now = 1'b0;
    end else if (calm || !take_lively) begin
      ready_now = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      ready_now = 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 14);
      ready_now = 1'b0;
    end else begin
      ready_now = 1'b1;
    end
    result_bus.ready <= ready_now;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (items_bus.valid && items_bus.ready) begin
        load_element(items_bus.data.perm_value);
        item_taken = 1'b1;
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        set_size = cfg_bus.data;
        elems_loaded = 0;
        pair_inversions = 0;
        size_taken = 1'b1;
      end
      if (result_bus.valid && result_bus.ready) begin
        if (due_rotations.size() == 0) begin
          bad_results++;
          if (bad_results <= 10) begin
            $display("unexpected result: q=%0d cost=%0d min=%0d last=%0d",
                     result_bus.data.rotation_index, result_bus.data.rotation_cost,
                     result_bus.data.running_minimum, result_bus.data.last_of_run);
          end
        end else begin
          if (result_bus.data !== due_rotations[0]) begin
            bad_results++;
            if (bad_results <= 10) begin
              $display({"result mismatch: expected q=%0d cost=%0d min=%0d last=%0d,",
                        " got q=%0d cost=%0d min=%0d last=%0d"},
                       due_rotations[0].rotation_index, due_rotations[0].rotation_cost,
                       due_rotations[0].running_minimum, due_rotations[0].last_of_run,
                       result_bus.data.rotation_index, result_bus.data.rotation_cost,
                       result_bus.data.running_minimum, result_bus.data.last_of_run);
            end
          end
          void'(due_rotations.pop_front());
        end
      end
    end
  end

endmodule
